@@ hdl/lba_pkg.sv @@
// ----------------------------------------------------------------------------
// lba_pkg
// Types, codes and constants shared by the LVDS bitslip aligner.
// ----------------------------------------------------------------------------
package lba_pkg;

    localparam int unsigned LANE_W    = 3;
    localparam int unsigned COUNT_W   = 10;
    localparam int unsigned MASK_W    = 10;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned CHAN_W    = 3;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_W     = 10;

    localparam logic [LANE_W-1:0]  SYNC_LANE     = 3'd4;
    localparam logic [7:0]         TRAIN_WORD    = 8'he9;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 10'd1023;
    localparam logic [COUNT_W-1:0] LIMIT_RESET   = 10'd1000;
    localparam logic [3:0]         IMAGER_OFFSET = 4'd5;

    localparam logic [7:0] SYNC_WORDS [8] = '{
        8'h0d, 8'h0a, 8'he9, 8'haa, 8'hca, 8'h4a, 8'h16, 8'h05
    };

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_BUSY    = 2'd1,
        ST_ALIGNED = 2'd2,
        ST_FAILED  = 2'd3
    } status_t;

    typedef enum logic {
        CMD_START  = 1'b0,
        CMD_SAMPLE = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGER_SELECT = 1'b0,
        REG_ATTEMPT_LIMIT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [LANE_W-1:0]  phase;
        logic [COUNT_W-1:0] attempt_count;
        status_t            run_status;
    } train_state_t;

    typedef struct packed {
        logic [CHAN_W-1:0] read_channel;
        logic [MASK_W-1:0] bitslip_mask;
        status_t           status;
        logic [LANE_W-1:0] lane;
    } train_result_t;

    function automatic logic is_sync_word(input logic [7:0] b);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (SYNC_WORDS[i] == b)
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

@@ hdl/lba_stream_if.sv @@
// ----------------------------------------------------------------------------
// lba_in_if / lba_out_if
// Valid/ready channels carrying sample commands in and training results out.
// ----------------------------------------------------------------------------
interface lba_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] pio_word;

    modport source (output valid, output cmd, output pio_word, input ready);
    modport sink   (input valid, input cmd, input pio_word, output ready);
endinterface

interface lba_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] read_channel;
    logic [9:0] bitslip_mask;
    logic [1:0] status;
    logic [2:0] lane;

    modport source (output valid, output read_channel, output bitslip_mask,
                    output status, output lane, input ready);
    modport sink   (input valid, input read_channel, input bitslip_mask,
                    input status, input lane, output ready);
endinterface

@@ hdl/lvds_bitslip_aligner.sv @@
// ----------------------------------------------------------------------------
// lvds_bitslip_aligner
// An input passes the input register, the judge, then the result register.
// Throughput: one transaction per cycle; input register feeds one judging
// stage into a result register, with ready gated only by a full result.
// Reset: training state idle on the sync lane, imager 0, attempt limit 1000.
// ----------------------------------------------------------------------------
module lvds_bitslip_aligner #(
    parameter int unsigned DATA_LANES = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    lba_in_if.sink                          in_ch,
    lba_out_if.source                       out_ch,
    input  logic                            cfg_we,
    input  logic [lba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lba_pkg::CFG_W-1:0]       cfg_wdata
);
    import lba_pkg::*;

    logic               in_valid_reg;
    logic               cmd_reg;
    logic [WORD_W-1:0]  word_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    train_result_t      result_reg;
    train_result_t      result_next;
    train_state_t       state_reg;
    train_state_t       state_next;
    logic               imager_reg;
    logic [COUNT_W-1:0] limit_reg;
    logic               advance;

    assign advance      = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !in_valid_reg || advance;
    assign out_valid_next = advance || (out_valid_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            imager_reg <= 1'b0;
            limit_reg  <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_IMAGER_SELECT: imager_reg <= cfg_wdata[0];
                REG_ATTEMPT_LIMIT: limit_reg  <= cfg_wdata[COUNT_W-1:0];
                default:           limit_reg  <= limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            cmd_reg  <= in_ch.cmd;
            word_reg <= in_ch.pio_word;
        end
    end

    lba_judge #(
        .DATA_LANES (DATA_LANES)
    ) u_judge (
        .cmd           (cmd_reg),
        .pio_word      (word_reg),
        .imager_select (imager_reg),
        .attempt_limit (limit_reg),
        .state_cur     (state_reg),
        .state_next    (state_next),
        .result        (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase         <= SYNC_LANE;
            state_reg.attempt_count <= '0;
            state_reg.run_status    <= ST_IDLE;
            out_valid_reg           <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.read_channel = result_reg.read_channel;
    assign out_ch.bitslip_mask = result_reg.bitslip_mask;
    assign out_ch.status       = result_reg.status;
    assign out_ch.lane         = result_reg.lane;

    // at most one lane slips per transaction, and only while a run is live
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot0(result_reg.bitslip_mask))
        else $error("more than one slip bit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.bitslip_mask != '0) |->
        (result_reg.status == ST_BUSY || result_reg.status == ST_FAILED))
        else $error("slip outside a run");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.run_status == ST_ALIGNED || state_reg.run_status == ST_IDLE) |->
        (state_reg.phase == SYNC_LANE && state_reg.attempt_count == '0))
        else $error("done state not parked on sync lane");

    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("training state moved without a transaction");

endmodule

@@ hdl/lba_judge.sv @@
// ----------------------------------------------------------------------------
// lba_judge
// Starts a run or judges a sampled word on the training lane, giving the
// next training state and the result (channel, slip mask, status, lane).
// ----------------------------------------------------------------------------
module lba_judge #(
    parameter int unsigned DATA_LANES = 4
) (
    input  logic                           cmd,
    input  logic [31:0]                    pio_word,
    input  logic                           imager_select,
    input  logic [lba_pkg::COUNT_W-1:0]    attempt_limit,
    input  lba_pkg::train_state_t          state_cur,
    output lba_pkg::train_state_t          state_next,
    output lba_pkg::train_result_t         result
);
    import lba_pkg::*;

    logic [COUNT_W-1:0] count_inc;
    logic               on_sync;
    logic [7:0]         lane_byte;
    logic               pass;
    logic               slip;
    logic [3:0]         slip_idx;
    logic [MASK_W-1:0]  mask;
    logic               last_lane;
    logic [LANE_W-1:0]  chan_lane;

    assign count_inc = (state_cur.attempt_count == COUNT_MAX) ?
                       state_cur.attempt_count : state_cur.attempt_count + 1'b1;
    assign on_sync   = (state_cur.phase == SYNC_LANE);
    assign lane_byte = on_sync ? pio_word[31:24] : pio_word[23:16];
    assign pass      = on_sync ? is_sync_word(lane_byte) : (lane_byte == TRAIN_WORD);
    assign slip      = !pass && (!on_sync || lane_byte != 8'h00);
    assign slip_idx  = {1'b0, state_cur.phase} + (imager_select ? IMAGER_OFFSET : 4'd0);
    assign last_lane = ({1'b0, state_cur.phase} + 4'd1) >= 4'(DATA_LANES);

    always_comb
    begin
        state_next = state_cur;
        mask       = '0;
        if (cmd == CMD_START)
        begin
            state_next.phase         = SYNC_LANE;
            state_next.attempt_count = '0;
            state_next.run_status    = ST_BUSY;
        end
        else if (state_cur.run_status == ST_BUSY)
        begin
            if (slip)
            begin
                mask = MASK_W'(1) << slip_idx;
            end
            if (pass)
            begin
                state_next.attempt_count = '0;
                if (on_sync)
                begin
                    state_next.phase = '0;
                end
                else if (last_lane)
                begin
                    state_next.phase      = SYNC_LANE;
                    state_next.run_status = ST_ALIGNED;
                end
                else
                begin
                    state_next.phase = state_cur.phase + 1'b1;
                end
            end
            else
            begin
                state_next.attempt_count = count_inc;
                if (count_inc >= attempt_limit)
                begin
                    state_next.run_status = ST_FAILED;
                end
            end
        end
    end

    assign chan_lane = (state_next.phase == SYNC_LANE) ? '0 : state_next.phase;

    assign result.read_channel = CHAN_W'(chan_lane + {imager_select, 2'b00});
    assign result.bitslip_mask = mask;
    assign result.status       = state_next.run_status;
    assign result.lane         = state_next.phase;

endmodule
